@@ rtl/crcff_pkg.sv @@
package crcff_pkg;

    localparam int unsigned CountBitsDefault = 32;
    localparam logic [31:0] CrcPoly = 32'hEDB88320;
    localparam int unsigned ByteShift = 24;

    typedef struct packed {
        logic [31:0] s;
        logic [31:0] add;
    } t_word;

    // carryless product of two 32-bit values
    function automatic logic [63:0] clmul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] acc;
        acc = '0;
        for (int i = 0; i < 32; i++) begin
            if (a[i]) begin
                acc = acc ^ ({32'h0, b} << i);
            end
        end
        return acc;
    endfunction

    // reflected reduction of 64 bits down to 32
    function automatic logic [31:0] fold(input logic [63:0] w);
        logic [63:0] v;
        logic        low;
        v = w;
        for (int i = 0; i < 32; i++) begin
            low = v[0];
            v = v >> 1;
            if (low) begin
                v = v ^ {32'h0, CrcPoly};
            end
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] mulmod(input logic [31:0] a, input logic [31:0] b);
        return fold(clmul(a, b));
    endfunction

    // multiplier for 2^idx bytes, squared up from one byte
    function automatic logic [31:0] stage_mult(input int unsigned idx);
        logic [31:0] m;
        m = 32'h1 << ByteShift;
        for (int unsigned i = 0; i < idx; i++) begin
            m = mulmod(m, m);
        end
        return m;
    endfunction

endpackage

@@ rtl/crcff_stage.sv @@
module crcff_stage #(
    parameter int unsigned COUNT_BITS = crcff_pkg::CountBitsDefault,
    parameter int unsigned IDX = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  crcff_pkg::t_word        i_data,
    input  logic [COUNT_BITS-1:0]   i_count,
    output logic                    o_valid,
    output crcff_pkg::t_word        o_data,
    output logic [COUNT_BITS-1:0]   o_count
);

    localparam logic [31:0] Mult = crcff_pkg::stage_mult(IDX);

    logic [31:0] s_terms [32];
    logic [31:0] f_terms [32];
    logic [31:0] a_terms [32];
    logic [31:0] s_mul;
    logic [31:0] a_fold;
    logic [31:0] a_mul;

    logic                  r_valid;
    crcff_pkg::t_word      r_data;
    logic [COUNT_BITS-1:0] r_count;
    crcff_pkg::t_word      n_data;

    // constant multiply as fixed xor columns
    for (genvar j = 0; j < 32; j++) begin : g_col
        localparam logic [31:0] ColMul  = crcff_pkg::mulmod(32'h1 << j, Mult);
        localparam logic [31:0] ColFold = crcff_pkg::fold(64'h1 << j);
        assign s_terms[j] = {32{i_data.s[j]}} & ColMul;
        assign f_terms[j] = {32{i_data.add[j]}} & ColFold;
        assign a_terms[j] = {32{i_data.add[j]}} & ColMul;
    end

    always_comb begin
        s_mul  = '0;
        a_fold = '0;
        a_mul  = '0;
        for (int j = 0; j < 32; j++) begin
            s_mul  = s_mul ^ s_terms[j];
            a_fold = a_fold ^ f_terms[j];
            a_mul  = a_mul ^ a_terms[j];
        end
        n_data.s   = i_count[IDX] ? (s_mul ^ a_fold) : i_data.s;
        n_data.add = a_mul ^ i_data.add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data  <= n_data;
            r_count <= i_count;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_count = r_count;

endmodule

@@ rtl/crc32_repeated_byte_fast_forward.sv @@
// crc32 fast-forward over a run of identical pad bytes
// input channel: i_valid / o_stall carry i_crc_in, i_pad_byte, i_repeat_count;
// a word is taken on a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall carry o_crc_out, taken when o_valid high
// and i_stall low
// one pipeline stage per count bit, each applying the constant map for
// 2^k bytes, plus an input and an output register
// from acceptance, a word passes the input register, each stage in order and the output register to o_valid
// throughput: one word per cycle while the output is not stalled
// when the receiver stalls a held result, the whole pipeline freezes and
// o_stall rises in the same cycle; nothing is lost or repeated
// reset (synchronous, active low) empties the pipeline; there is no other
// state, so the block is ready on the first cycle after reset
// a zero count returns i_crc_in unchanged
module crc32_repeated_byte_fast_forward #(
    parameter int unsigned COUNT_BITS = crcff_pkg::CountBitsDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [31:0]           i_crc_in,
    input  logic [7:0]            i_pad_byte,
    input  logic [COUNT_BITS-1:0] i_repeat_count,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [31:0]           o_crc_out
);

    logic                  en;
    logic                  v   [COUNT_BITS+1];
    crcff_pkg::t_word      d   [COUNT_BITS+1];
    logic [COUNT_BITS-1:0] c   [COUNT_BITS+1];

    logic                  r_v0;
    crcff_pkg::t_word      r_d0;
    logic [COUNT_BITS-1:0] r_c0;
    logic                  r_out_valid;
    logic [31:0]           r_out;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v0        <= i_valid;
            r_out_valid <= v[COUNT_BITS];
        end
        if (en) begin
            r_d0.s   <= ~i_crc_in;
            r_d0.add <= {i_pad_byte, 24'h0};
            r_c0     <= i_repeat_count;
            r_out    <= ~d[COUNT_BITS].s;
        end
    end

    assign v[0] = r_v0;
    assign d[0] = r_d0;
    assign c[0] = r_c0;

    for (genvar k = 0; k < COUNT_BITS; k++) begin : g_stage
        crcff_stage #(
            .COUNT_BITS(COUNT_BITS),
            .IDX       (k)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(v[k]),
            .i_data (d[k]),
            .i_count(c[k]),
            .o_valid(v[k+1]),
            .o_data (d[k+1]),
            .o_count(c[k+1])
        );
    end

    assign o_valid   = r_out_valid;
    assign o_crc_out = r_out;

endmodule

@@ rtl/crcff_checker.sv @@
module crcff_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_crc_out
);

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_crc_out))
        else $error("held word changed");

    // upstream is stalled only by a stalled result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("stall mismatch");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind crc32_repeated_byte_fast_forward crcff_checker u_crcff_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_crc_out(o_crc_out)
);

@@ tb/crc32_repeated_byte_fast_forward_tb.sv @@
`timescale 1ns / 1ps

module crc32_repeated_byte_fast_forward_tb;

    localparam int unsigned CountBits = crcff_pkg::CountBitsDefault;
    localparam int unsigned Latency = CountBits + 2;
    localparam logic [31:0] Poly = 32'hEDB88320;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [31:0]          i_crc_in = '0;
    logic [7:0]           i_pad_byte = '0;
    logic [CountBits-1:0] i_repeat_count = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [31:0]          o_crc_out;

    logic [31:0] expected_crcs[$];
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_zero_count = 0;
    bit          hold_off = 1'b0;
    int          rx_wait = 0;
    int          rx_draw = 0;

    crc32_repeated_byte_fast_forward #(
        .COUNT_BITS(CountBits)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_crc_in(i_crc_in),
        .i_pad_byte(i_pad_byte),
        .i_repeat_count(i_repeat_count),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_crc_out(o_crc_out)
    );

    always #4 i_clk = ~i_clk;

    // reflected reduction of 64 bits down to 32
    function automatic logic [31:0] gf_fold(input logic [63:0] w);
        logic [63:0] v;
        logic        low;
        v = w;
        for (int i = 0; i < 32; i++) begin
            low = v[0];
            v = v >> 1;
            if (low) begin
                v = v ^ {32'h0, Poly};
            end
        end
        return v[31:0];
    endfunction

    // a*b mod P in the reflected domain
    function automatic logic [31:0] gf_mulmod(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] acc;
        logic        low;
        acc = '0;
        for (int i = 0; i < 32; i++) begin
            if (a[i]) begin
                acc = acc ^ ({32'h0, b} << i);
            end
        end
        for (int i = 0; i < 32; i++) begin
            low = acc[0];
            acc = acc >> 1;
            if (low) begin
                acc = acc ^ {32'h0, Poly};
            end
        end
        return acc[31:0];
    endfunction

    function automatic logic [31:0] crc_after_pad(input logic [31:0] crc, input logic [7:0] pad,
                                                  input logic [CountBits-1:0] count);
        logic [31:0]          s;
        logic [31:0]          mul;
        logic [31:0]          add;
        logic [CountBits-1:0] n;
        s = ~crc;
        mul = 32'h1 << 24;
        add = {pad, 24'h0};
        n = count;
        while (n != 0) begin
            if (n[0]) begin
                // the offset enters before the reduction
                s = gf_mulmod(s, mul) ^ gf_fold({32'h0, add});
            end
            n = n >> 1;
            if (n != 0) begin
                add = gf_mulmod(add, mul) ^ add;
                mul = gf_mulmod(mul, mul);
            end
        end
        return ~s;
    endfunction

    task automatic send_word(input logic [31:0] crc, input logic [7:0] pad,
                             input logic [CountBits-1:0] count);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_crc_in <= crc;
        i_pad_byte <= pad;
        i_repeat_count <= count;
        do @(posedge i_clk); while (o_stall);
        expected_crcs.push_back(crc_after_pad(crc, pad, count));
        n_sent++;
        if (count == 0) n_zero_count++;
    endtask

    // receiver: stalls for a randomly drawn gap after each word it takes, or holds off while hold_off is set
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_stall <= 1'b1;
        end else if (rx_wait != 0) begin
            i_stall <= 1'b1;
            rx_wait <= rx_wait - 1;
        end else if (o_valid && !i_stall) begin
            rx_draw = $urandom_range(0, 3);
            i_stall <= (rx_draw != 0);
            rx_wait <= (rx_draw != 0) ? rx_draw - 1 : 0;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_crcs.size() == 0) begin
                $error("crc_out: unexpected word, actual %h", o_crc_out);
                n_errors++;
            end else begin
                if (o_crc_out !== expected_crcs[0]) begin
                    $error("crc_out: expected %h actual %h", expected_crcs[0], o_crc_out);
                    n_errors++;
                end
                void'(expected_crcs.pop_front());
                n_checked++;
            end
        end
    end

    function automatic logic [CountBits-1:0] rand_count();
        logic [CountBits-1:0] c;
        c = CountBits'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: c = c & CountBits'('hf);
            1: c = c & CountBits'('hffff);
            default: ;
        endcase
        return c;
    endfunction

    task automatic test_directed();
        send_word(32'h0, 8'h00, '0);
        send_word(32'hffffffff, 8'hff, '0);
        send_word(32'h12345678, 8'hab, '0);
        send_word(32'h0, 8'h00, CountBits'(1));
        send_word(32'hffffffff, 8'hff, CountBits'(1));
        send_word(32'h0, 8'hff, '1);
        send_word(32'hffffffff, 8'h00, '1);
        send_word(32'hdeadbeef, 8'h5a, CountBits'(2));
        send_word(32'h0, 8'h00, CountBits'(3));
        send_word(32'hcbf43926, 8'h31, CountBits'(8));
        for (int k = 0; k < CountBits; k++) begin
            send_word($urandom, 8'($urandom), CountBits'(1) << k);
        end
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++) begin
            send_word($urandom, 8'($urandom), rand_count());
        end
    endtask

    // receiver holds off long enough that the pipeline backs up
    task automatic test_backpressure();
        fork
            begin
                hold_off <= 1'b1;
                repeat (3 * Latency) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            test_random(2 * Latency);
        join
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_crcs.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(300);
        test_backpressure();
        test_random(340);
        i_valid <= 1'b0;
        drain();
        $display("sent %0d words (%0d with zero count), checked %0d results", n_sent,
                 n_zero_count, n_checked);
        $display("covered extremes, each single count bit, random counts, long backpressure");
        if (n_errors == 0 && expected_crcs.size() == 0) begin
            $display("crc32_repeated_byte_fast_forward_tb OK");
        end else begin
            $display("crc32_repeated_byte_fast_forward_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("crc32_repeated_byte_fast_forward_tb NOT OK");
        $finish;
    end

endmodule
